/* rtl/tlct_pkg.sv */
`timescale 1ns / 1ps
// Package for the two-level cache tag model: channel words, memory entries,
// register indexes, reset values and sequencer states. No dependencies.
package tlct_pkg;

   localparam int TAG_W      = 32;
   localparam int STAMP_W    = 64;
   localparam int ADDR_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_L1_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_L2_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_L2_WAYS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLK_SIZE = 2'd3;

   localparam logic [4:0] L1_SIZE_RESET  = 5'd12;
   localparam logic [4:0] L2_SIZE_RESET  = 5'd15;
   localparam logic [1:0] L2_WAYS_RESET  = 2'd2;
   localparam logic [2:0] BLK_SIZE_RESET = 3'd5;

   localparam logic KIND_WRITE = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic l1_miss;
      logic l2_miss;
      logic write_back;
      logic back_invalidate;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic             dirty;
      logic [TAG_W-1:0] tag;
   } l1_entry_type;

   typedef struct packed {
      logic               valid;
      logic               dirty;
      logic [STAMP_W-1:0] stamp;
      logic [TAG_W-1:0]   tag;
   } l2_entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_L1_RD,
      ST_L1_CHK,
      ST_SCAN,
      ST_L2_UPD,
      ST_VIC_RD,
      ST_VIC_CHK,
      ST_FILL,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MODE_REFRESH,
      MODE_MARK,
      MODE_MAIN
   } mode_type;

endpackage

/* rtl/tlct_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tlct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/two_level_inclusive_cache_tags.sv */
`timescale 1ns / 1ps
// Top level of the two-level cache tag model: sequencer, geometry and datapath.
// Depends on tlct_pkg and tlct_ram.
//
// Usage: each word on the req channel is one access (kind, byte address). The
// block answers every access with exactly one word on the rsp channel carrying
// the L1 miss, L2 miss, write-back and back-invalidate flags. The csr channel
// writes the four geometry registers (index 0 to 3); it is always ready, and
// should be written only while no access is outstanding.
// Sequence: an access reads and checks its L1 line, then scans the active L2
// ways of its set. A dirty L1 eviction first scans the set of the evicted line
// to mark it dirty in L2, and an L2 miss with a full set reads the victim's L1
// line and back-invalidates a matching copy before the fill. The scans walk the
// ways of a set one per cycle through the single read port of the L2 tag RAM.
// One access is in flight at a time; req_ready is low from acceptance until the
// response is registered.
// Reset: a clearing pass zeroes the valid, dirty and stamp bits; req_ready stays
// low during the pass.
// Stall: the response waits in an output register while rsp_ready is low; the
// next access can be accepted meanwhile, but its own response waits until the
// register is free.
module two_level_inclusive_cache_tags #(
   parameter int L1_LINES   = 1024,
   parameter int L2_SETS    = 1024,
   parameter int L2_WAYS    = 8,
   parameter int ADDR_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  tlct_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output tlct_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tlct_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tlct_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int TW        = tlct_pkg::TAG_W;
   localparam int L1_IW     = L1_LINES > 1 ? $clog2(L1_LINES) : 1;
   localparam int L1_CAP    = $clog2(L1_LINES + 1) - 1;
   localparam int SET_W     = L2_SETS > 1 ? $clog2(L2_SETS) : 1;
   localparam int L2_CAP    = $clog2(L2_SETS + 1) - 1;
   localparam int WCNT_W    = $clog2(L2_WAYS + 1);
   localparam int L2_DEPTH  = L2_SETS * L2_WAYS;
   localparam int L2_AW     = L2_DEPTH > 1 ? $clog2(L2_DEPTH) : 1;
   localparam int CLR_DEPTH = L2_DEPTH > L1_LINES ? L2_DEPTH : L1_LINES;
   localparam int CLR_W     = $clog2(CLR_DEPTH + 1);
   localparam int OB_W      = TW + L1_IW;
   localparam int VB_W      = TW + SET_W;
   localparam logic [31:0] ADDR_MASK = (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                       32'((64'd1 << ADDR_WIDTH) - 64'd1);

   tlct_pkg::state_type    state_ff, state_in;
   tlct_pkg::mode_type     mode_ff;
   logic [4:0]             l1s_ff, l2s_ff;
   logic [1:0]             wl_ff;
   logic [2:0]             bs_ff;
   logic [CLR_W-1:0]       clr_cnt_ff;
   logic                   wr_ff;
   logic [31:0]            addr_ff;
   logic [tlct_pkg::STAMP_W-1:0] cnt_ff;
   logic [SET_W-1:0]       scan_set_ff;
   logic [OB_W-1:0]        scan_tag_ff;
   logic [WCNT_W-1:0]      scan_cnt_ff;
   logic                   hit_found_ff, inv_found_ff;
   logic [WCNT_W-1:0]      hit_way_ff, inv_way_ff, min_way_ff;
   tlct_pkg::l2_entry_type hit_ent_ff, min_ent_ff;
   logic                   l1m_ff, l2m_ff, wb_ff, binv_ff;
   logic                   rsp_valid_ff;
   tlct_pkg::rsp_type      rsp_ff;

   logic [4:0]             raw1, n1, sum2, raw2, n2, ways_n;
   logic [3:0]             wcount;
   logic [31:0]            blk, t1, t2;
   logic [L1_IW-1:0]       m1, i1, vi;
   logic [SET_W-1:0]       m2, s2, os;
   logic [OB_W-1:0]        ob, ot;
   logic [VB_W-1:0]        vb, vtag;
   logic                   l1_hit, scan_last, cmp_en, tag_hit;
   logic [WCNT_W-1:0]      cmp_way, upd_way;
   logic [L2_AW-1:0]       l2_base;

   tlct_pkg::l1_entry_type l1_q, l1_wdata;
   tlct_pkg::l2_entry_type l2_q, l2_wdata;
   logic                   l1_we, l2_we;
   logic [L1_IW-1:0]       l1_waddr, l1_raddr;
   logic [L2_AW-1:0]       l2_waddr, l2_raddr;
   logic                   accept, rsp_free;

   // Geometry from the configuration registers.
   always_comb begin
      raw1   = (l1s_ff > {2'b0, bs_ff}) ? l1s_ff - {2'b0, bs_ff} : 5'd0;
      n1     = (raw1 < 5'(L1_CAP)) ? raw1 : 5'(L1_CAP);
      sum2   = {3'b0, wl_ff} + {2'b0, bs_ff};
      raw2   = (l2s_ff > sum2) ? l2s_ff - sum2 : 5'd0;
      n2     = (raw2 < 5'(L2_CAP)) ? raw2 : 5'(L2_CAP);
      wcount = 4'd1 << wl_ff;
      ways_n = ({1'b0, wcount} < 5'(L2_WAYS)) ? {1'b0, wcount} : 5'(L2_WAYS);
      blk    = addr_ff >> bs_ff;
      m1     = ~({L1_IW{1'b1}} << n1);
      m2     = ~({SET_W{1'b1}} << n2);
      i1     = blk[L1_IW-1:0] & m1;
      t1     = blk >> n1;
      s2     = blk[SET_W-1:0] & m2;
      t2     = blk >> n2;
      l1_hit = l1_q.valid && (l1_q.tag == t1);
      ob     = (OB_W'(l1_q.tag) << n1) | OB_W'(i1);
      os     = ob[SET_W-1:0] & m2;
      ot     = ob >> n2;
      vb     = (VB_W'(min_ent_ff.tag) << n2) | VB_W'(s2);
      vi     = vb[L1_IW-1:0] & m1;
      vtag   = vb >> n1;
      scan_last = (5'(scan_cnt_ff) == ways_n);
      cmp_en    = (scan_cnt_ff != '0);
      cmp_way   = scan_cnt_ff - 1'b1;
      tag_hit   = l2_q.valid && (OB_W'(l2_q.tag) == scan_tag_ff);
      l2_base   = L2_AW'(scan_set_ff) * L2_AW'(L2_WAYS);
      upd_way   = (mode_ff == tlct_pkg::MODE_MAIN && !hit_found_ff) ?
                  (inv_found_ff ? inv_way_ff : min_way_ff) : hit_way_ff;
   end

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tlct_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == CLR_W'(CLR_DEPTH - 1)) begin
               state_in = tlct_pkg::ST_IDLE;
            end
         end
         tlct_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = tlct_pkg::ST_L1_RD;
            end
         end
         tlct_pkg::ST_L1_RD:  state_in = tlct_pkg::ST_L1_CHK;
         tlct_pkg::ST_L1_CHK: state_in = tlct_pkg::ST_SCAN;
         tlct_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = tlct_pkg::ST_L2_UPD;
            end
         end
         tlct_pkg::ST_L2_UPD: begin
            case (mode_ff)
               tlct_pkg::MODE_REFRESH: state_in = tlct_pkg::ST_DONE;
               tlct_pkg::MODE_MARK:    state_in = tlct_pkg::ST_SCAN;
               default: begin
                  if (!hit_found_ff && !inv_found_ff) begin
                     state_in = tlct_pkg::ST_VIC_RD;
                  end else begin
                     state_in = tlct_pkg::ST_FILL;
                  end
               end
            endcase
         end
         tlct_pkg::ST_VIC_RD:  state_in = tlct_pkg::ST_VIC_CHK;
         tlct_pkg::ST_VIC_CHK: state_in = tlct_pkg::ST_FILL;
         tlct_pkg::ST_FILL:    state_in = tlct_pkg::ST_DONE;
         tlct_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = tlct_pkg::ST_IDLE;
            end
         end
         default: state_in = tlct_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      l1_we     = 1'b0;
      l1_waddr  = i1;
      l1_wdata  = '{valid: 1'b1, dirty: 1'b0, tag: t1};
      l1_raddr  = i1;
      l2_we     = 1'b0;
      l2_waddr  = l2_base + L2_AW'(upd_way);
      l2_wdata  = hit_ent_ff;
      l2_raddr  = l2_base + L2_AW'(scan_cnt_ff);
      case (state_ff)
         tlct_pkg::ST_CLEAR: begin
            l1_we    = (clr_cnt_ff < CLR_W'(L1_LINES));
            l1_waddr = L1_IW'(clr_cnt_ff);
            l1_wdata = '0;
            l2_we    = (clr_cnt_ff < CLR_W'(L2_DEPTH));
            l2_waddr = L2_AW'(clr_cnt_ff);
            l2_wdata = '0;
         end
         tlct_pkg::ST_IDLE: req_ready = 1'b1;
         tlct_pkg::ST_L1_CHK: begin
            l1_we    = l1_hit && (wr_ff == tlct_pkg::KIND_WRITE);
            l1_wdata = '{valid: 1'b1, dirty: 1'b1, tag: t1};
         end
         tlct_pkg::ST_L2_UPD: begin
            case (mode_ff)
               tlct_pkg::MODE_REFRESH: begin
                  l2_we          = hit_found_ff;
                  l2_wdata.stamp = cnt_ff;
               end
               tlct_pkg::MODE_MARK: begin
                  l2_we          = hit_found_ff;
                  l2_wdata.dirty = 1'b1;
               end
               default: begin
                  l2_we = 1'b1;
                  if (hit_found_ff) begin
                     l2_wdata.stamp = cnt_ff;
                     l2_wdata.dirty = hit_ent_ff.dirty || (wr_ff == tlct_pkg::KIND_WRITE);
                  end else begin
                     l2_wdata = '{valid: 1'b1, dirty: wr_ff, stamp: cnt_ff, tag: t2};
                  end
               end
            endcase
         end
         tlct_pkg::ST_VIC_RD: l1_raddr = vi;
         tlct_pkg::ST_VIC_CHK: begin
            l1_waddr = vi;
            l1_we    = l1_q.valid && (VB_W'(l1_q.tag) == vtag);
            l1_wdata = '{valid: 1'b0, dirty: 1'b0, tag: l1_q.tag};
         end
         tlct_pkg::ST_FILL: l1_we = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlct_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         l1s_ff       <= tlct_pkg::L1_SIZE_RESET;
         l2s_ff       <= tlct_pkg::L2_SIZE_RESET;
         wl_ff        <= tlct_pkg::L2_WAYS_RESET;
         bs_ff        <= tlct_pkg::BLK_SIZE_RESET;
      end else begin
         state_ff <= state_in;
         if (state_ff == tlct_pkg::ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (accept) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (state_ff == tlct_pkg::ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            case (csr_index)
               tlct_pkg::CSR_L1_SIZE:  l1s_ff <= csr_data[4:0];
               tlct_pkg::CSR_L2_SIZE:  l2s_ff <= csr_data[4:0];
               tlct_pkg::CSR_L2_WAYS:  wl_ff  <= csr_data[1:0];
               tlct_pkg::CSR_BLK_SIZE: bs_ff  <= csr_data[2:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         tlct_pkg::ST_IDLE: begin
            wr_ff   <= req_data.kind;
            addr_ff <= req_data.address & ADDR_MASK;
            l2m_ff  <= 1'b0;
            wb_ff   <= 1'b0;
            binv_ff <= 1'b0;
         end
         tlct_pkg::ST_L1_CHK: begin
            l1m_ff       <= !l1_hit;
            scan_cnt_ff  <= '0;
            hit_found_ff <= 1'b0;
            inv_found_ff <= 1'b0;
            if (l1_hit) begin
               mode_ff     <= tlct_pkg::MODE_REFRESH;
               scan_set_ff <= s2;
               scan_tag_ff <= OB_W'(t2);
            end else if (l1_q.valid && l1_q.dirty) begin
               mode_ff     <= tlct_pkg::MODE_MARK;
               scan_set_ff <= os;
               scan_tag_ff <= ot;
            end else begin
               mode_ff     <= tlct_pkg::MODE_MAIN;
               scan_set_ff <= s2;
               scan_tag_ff <= OB_W'(t2);
            end
         end
         tlct_pkg::ST_SCAN: begin
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
            if (cmp_en) begin
               if (tag_hit && !hit_found_ff) begin
                  hit_found_ff <= 1'b1;
                  hit_way_ff   <= cmp_way;
                  hit_ent_ff   <= l2_q;
               end
               if (!l2_q.valid && !inv_found_ff) begin
                  inv_found_ff <= 1'b1;
                  inv_way_ff   <= cmp_way;
               end
               if (cmp_way == '0 || l2_q.stamp < min_ent_ff.stamp) begin
                  min_way_ff <= cmp_way;
                  min_ent_ff <= l2_q;
               end
            end
         end
         tlct_pkg::ST_L2_UPD: begin
            if (mode_ff == tlct_pkg::MODE_MARK) begin
               mode_ff      <= tlct_pkg::MODE_MAIN;
               scan_set_ff  <= s2;
               scan_tag_ff  <= OB_W'(t2);
               scan_cnt_ff  <= '0;
               hit_found_ff <= 1'b0;
               inv_found_ff <= 1'b0;
            end else if (mode_ff == tlct_pkg::MODE_MAIN && !hit_found_ff) begin
               l2m_ff <= 1'b1;
               wb_ff  <= !inv_found_ff && min_ent_ff.dirty;
            end
         end
         tlct_pkg::ST_VIC_CHK: begin
            binv_ff <= l1_we;
         end
         tlct_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_ff <= '{l1_miss: l1m_ff, l2_miss: l2m_ff,
                           write_back: wb_ff, back_invalidate: binv_ff};
            end
         end
         default: begin
         end
      endcase
   end

   tlct_ram #(
      .WIDTH ($bits(tlct_pkg::l1_entry_type)),
      .DEPTH (L1_LINES)
   ) u_l1_ram (
      .clock   (clock),
      .wr_en   (l1_we),
      .wr_addr (l1_waddr),
      .wr_data (l1_wdata),
      .rd_addr (l1_raddr),
      .rd_data (l1_q)
   );

   tlct_ram #(
      .WIDTH ($bits(tlct_pkg::l2_entry_type)),
      .DEPTH (L2_DEPTH)
   ) u_l2_ram (
      .clock   (clock),
      .wr_en   (l2_we),
      .wr_addr (l2_waddr),
      .wr_data (l2_wdata),
      .rd_addr (l2_raddr),
      .rd_data (l2_q)
   );

endmodule

/* rtl/tlct_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the two-level cache tag model, bound to the top level.
// Depends on tlct_pkg.
module tlct_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tlct_pkg::rsp_type rsp_data
);

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // Only one access is in flight.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second access accepted while busy");

   // An L2 miss is only reported with an L1 miss, and evictions only with an L2 miss.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.l2_miss || rsp_data.l1_miss) &&
                    (!(rsp_data.write_back || rsp_data.back_invalidate) ||
                     rsp_data.l2_miss))
      else $error("inconsistent response flags");

   // The clearing pass after reset blocks accesses and responses.
   a_reset: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block active right after reset");

endmodule

bind two_level_inclusive_cache_tags tlct_checker u_tlct_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* test/two_level_inclusive_cache_tags_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for two_level_inclusive_cache_tags: directed and random
// accesses under several cache geometries, checked against a behavioral tag model.
// Depends on tlct_pkg and the RTL of the block.
module two_level_inclusive_cache_tags_tb;

   localparam int N_L1 = 1024;
   localparam int N_SETS = 1024;
   localparam int N_WAYS = 8;
   localparam int LAT_PAD = 40;
   localparam int WATCH_LIMIT = 30000;
   localparam int N_PHASES = 8;
   localparam int PHASE_ITEMS = 130;

   typedef struct {
      logic              kind;
      logic [31:0]       addr;
      bit                known;
      tlct_pkg::rsp_type want;
   } dir_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   tlct_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   tlct_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [tlct_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [tlct_pkg::CSR_DATA_W-1:0] csr_data;

   logic [31:0] tag1 [N_L1];
   bit          vld1 [N_L1];
   bit          drt1 [N_L1];
   logic [31:0] tag2 [N_SETS*N_WAYS];
   bit          vld2 [N_SETS*N_WAYS];
   bit          drt2 [N_SETS*N_WAYS];
   logic [63:0] stamp2 [N_SETS*N_WAYS];
   logic [63:0] tick;
   int cfg_l1, cfg_l2, cfg_ways, cfg_blk;

   tlct_pkg::rsp_type pending_flags[$];
   bit idle_on;
   bit failed;
   int watch_count;
   int n_access, n_l1_miss, n_l2_miss, n_wb, n_binv, n_cfg;
   logic [31:0] addr_pool [16];
   dir_row_type dir_tab [12];

   two_level_inclusive_cache_tags DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int sat_bits(int total, int sub, int cap);
      int raw;
      raw = total > sub ? total - sub : 0;
      return raw < cap ? raw : cap;
   endfunction

   function automatic int find_way(logic [63:0] set, logic [63:0] tag, int ways);
      for (int w = 0; w < ways; w++) begin
         if (vld2[set*N_WAYS+w] && {32'd0, tag2[set*N_WAYS+w]} == tag) begin
            return w;
         end
      end
      return -1;
   endfunction

   function automatic tlct_pkg::rsp_type predict_access(tlct_pkg::req_type r);
      tlct_pkg::rsp_type f;
      int n1, n2, ways, w, v;
      logic [63:0] m1, m2, blk, i1, t1, s2, t2, ob, os, vb, vi, e, best;
      bit wr;
      wr = (r.kind == tlct_pkg::KIND_WRITE);
      n1 = sat_bits(cfg_l1, cfg_blk, 10);
      n2 = sat_bits(cfg_l2, cfg_ways + cfg_blk, 10);
      ways = (1 << cfg_ways) < N_WAYS ? (1 << cfg_ways) : N_WAYS;
      m1 = (64'd1 << n1) - 1;
      m2 = (64'd1 << n2) - 1;
      blk = {32'd0, r.address} >> cfg_blk;
      i1 = blk & m1;
      t1 = blk >> n1;
      s2 = blk & m2;
      t2 = blk >> n2;
      f = '0;
      tick = tick + 1;
      if (vld1[i1] && {32'd0, tag1[i1]} == t1) begin
         w = find_way(s2, t2, ways);
         if (w >= 0) stamp2[s2*N_WAYS+w] = tick;
         if (wr) drt1[i1] = 1'b1;
      end else begin
         f.l1_miss = 1'b1;
         if (vld1[i1] && drt1[i1]) begin
            ob = ({32'd0, tag1[i1]} << n1) | i1;
            os = ob & m2;
            w = find_way(os, ob >> n2, ways);
            if (w >= 0) drt2[os*N_WAYS+w] = 1'b1;
         end
         drt1[i1] = 1'b0;
         w = find_way(s2, t2, ways);
         if (w >= 0) begin
            e = s2*N_WAYS + w;
            stamp2[e] = tick;
            if (wr) drt2[e] = 1'b1;
         end else begin
            f.l2_miss = 1'b1;
            v = ways;
            for (int k = 0; k < ways; k++) begin
               if (!vld2[s2*N_WAYS+k]) begin
                  v = k;
                  break;
               end
            end
            if (v == ways) begin
               v = 0;
               best = stamp2[s2*N_WAYS];
               for (int k = 1; k < ways; k++) begin
                  if (stamp2[s2*N_WAYS+k] < best) begin
                     best = stamp2[s2*N_WAYS+k];
                     v = k;
                  end
               end
               e = s2*N_WAYS + v;
               if (drt2[e]) f.write_back = 1'b1;
               vb = ({32'd0, tag2[e]} << n2) | s2;
               vi = vb & m1;
               if (vld1[vi] && {32'd0, tag1[vi]} == (vb >> n1)) begin
                  vld1[vi] = 1'b0;
                  drt1[vi] = 1'b0;
                  f.back_invalidate = 1'b1;
               end
            end
            e = s2*N_WAYS + v;
            tag2[e] = t2[31:0];
            vld2[e] = 1'b1;
            drt2[e] = wr;
            stamp2[e] = tick;
         end
         tag1[i1] = t1[31:0];
         vld1[i1] = 1'b1;
      end
      return f;
   endfunction

   task automatic send_access(logic kind, logic [31:0] addr, bit known,
                              tlct_pkg::rsp_type want);
      tlct_pkg::rsp_type f;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{kind: kind, address: addr};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      f = predict_access('{kind: kind, address: addr});
      pending_flags.push_back(known ? want : f);
      n_access++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_flags.size() != 0) @(posedge clock);
      repeat (LAT_PAD) @(posedge clock);
   endtask

   task automatic write_reg(logic [tlct_pkg::CSR_IDX_W-1:0] idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[tlct_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         tlct_pkg::CSR_L1_SIZE: cfg_l1 = value & 31;
         tlct_pkg::CSR_L2_SIZE: cfg_l2 = value & 31;
         tlct_pkg::CSR_L2_WAYS: cfg_ways = value & 3;
         default: cfg_blk = value & 7;
      endcase
      n_cfg++;
   endtask

   task automatic set_geometry(int l1, int l2, int ways, int blk);
      drain();
      write_reg(tlct_pkg::CSR_L1_SIZE, l1);
      write_reg(tlct_pkg::CSR_L2_SIZE, l2);
      write_reg(tlct_pkg::CSR_L2_WAYS, ways);
      write_reg(tlct_pkg::CSR_BLK_SIZE, blk);
   endtask

   always @(posedge clock) begin
      tlct_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_flags.size() == 0) begin
            $display("%0t: response with nothing outstanding, actual %b", $time, rsp_data);
            failed = 1'b1;
         end else begin
            want = pending_flags.pop_front();
            if (rsp_data.l1_miss !== want.l1_miss) begin
               $display("%0t: l1_miss expected %b actual %b", $time, want.l1_miss,
                        rsp_data.l1_miss);
               failed = 1'b1;
            end
            if (rsp_data.l2_miss !== want.l2_miss) begin
               $display("%0t: l2_miss expected %b actual %b", $time, want.l2_miss,
                        rsp_data.l2_miss);
               failed = 1'b1;
            end
            if (rsp_data.write_back !== want.write_back) begin
               $display("%0t: write_back expected %b actual %b", $time, want.write_back,
                        rsp_data.write_back);
               failed = 1'b1;
            end
            if (rsp_data.back_invalidate !== want.back_invalidate) begin
               $display("%0t: back_invalidate expected %b actual %b", $time,
                        want.back_invalidate, rsp_data.back_invalidate);
               failed = 1'b1;
            end
            n_l1_miss += want.l1_miss;
            n_l2_miss += want.l2_miss;
            n_wb += want.write_back;
            n_binv += want.back_invalidate;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         watch_count <= 0;
      end else if (watch_count >= WATCH_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         watch_count <= watch_count + 1;
      end
   end

   initial begin
      rsp_ready = 1'b1;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   initial begin
      logic [31:0] addr;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = tlct_pkg::CSR_L1_SIZE;
      csr_data = '0;
      reset = 1'b1;
      failed = 1'b0;
      idle_on = 1'b1;
      watch_count = 0;
      tick = '0;
      cfg_l1 = int'(tlct_pkg::L1_SIZE_RESET);
      cfg_l2 = int'(tlct_pkg::L2_SIZE_RESET);
      cfg_ways = int'(tlct_pkg::L2_WAYS_RESET);
      cfg_blk = int'(tlct_pkg::BLK_SIZE_RESET);
      for (int i = 0; i < N_L1; i++) begin
         tag1[i] = '0;
         vld1[i] = 1'b0;
         drt1[i] = 1'b0;
      end
      for (int i = 0; i < N_SETS*N_WAYS; i++) begin
         tag2[i] = '0;
         vld2[i] = 1'b0;
         drt2[i] = 1'b0;
         stamp2[i] = '0;
      end
      dir_tab = '{
         '{1'b0, 32'h0000_0000, 1'b1, 4'b1100},
         '{1'b0, 32'h0000_0000, 1'b1, 4'b0000},
         '{1'b1, 32'h0000_0000, 1'b1, 4'b0000},
         '{1'b1, 32'hFFFF_FFFF, 1'b1, 4'b1100},
         '{1'b0, 32'h8000_0000, 1'b0, 4'b0000},
         '{1'b1, 32'h0000_2000, 1'b0, 4'b0000},
         '{1'b0, 32'h0000_4000, 1'b0, 4'b0000},
         '{1'b0, 32'h0000_6000, 1'b0, 4'b0000},
         '{1'b1, 32'h0000_8000, 1'b0, 4'b0000},
         '{1'b0, 32'h0000_0000, 1'b0, 4'b0000},
         '{1'b1, 32'h5555_5555, 1'b0, 4'b0000},
         '{1'b0, 32'hAAAA_AAAA, 1'b0, 4'b0000}
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         send_access(dir_tab[i].kind, dir_tab[i].addr, dir_tab[i].known, dir_tab[i].want);
      end

      for (int p = 0; p < N_PHASES; p++) begin
         case (p)
            0: set_geometry(0, 0, 0, 0);
            1: set_geometry(17, 22, 3, 7);
            2: set_geometry(31, 31, 3, 7);
            3: set_geometry(8, 9, 1, 2);
            4: set_geometry(12, 10, 3, 4);
            default: set_geometry($urandom_range(0, 31), $urandom_range(0, 31),
                                  $urandom_range(0, 3), $urandom_range(0, 7));
         endcase
         idle_on = (p != N_PHASES - 1);
         foreach (addr_pool[j]) addr_pool[j] = $urandom;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 3) == 0) begin
               addr = $urandom;
            end else begin
               addr = addr_pool[$urandom_range(0, 15)]
                      ^ ($urandom_range(0, 255) << $urandom_range(0, 10));
            end
            send_access(1'($urandom_range(0, 1)), addr, 1'b0, '0);
         end
      end

      drain();
      $display("Ran %0d accesses over %0d register writes: %0d L1 misses, %0d L2 misses,",
               n_access, n_cfg, n_l1_miss, n_l2_miss);
      $display("%0d write-backs and %0d back-invalidations.", n_wb, n_binv);
      if (!failed) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

/* filelist.f */
rtl/tlct_pkg.sv
rtl/tlct_ram.sv
rtl/two_level_inclusive_cache_tags.sv
rtl/tlct_checker.sv
test/two_level_inclusive_cache_tags_tb.sv
